// ===== hw/rtl/skrpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key run prefix encoder package
// Shared types, constants and helpers for the run encoder front, queue and back.
// ----------------------------------------------------------------------------
package skrpe_pkg;

  localparam int unsigned KeyBytes  = 32;
  localparam int unsigned KeyBits   = 8 * KeyBytes;
  localparam int unsigned PosBits   = $clog2(KeyBytes);
  localparam int unsigned LenBits   = 25;
  localparam int unsigned RemBits   = 24;
  localparam int unsigned QueueDepth = 2;

  localparam logic [LenBits-1:0] RunMax    = 25'd16843009;
  localparam logic [LenBits-1:0] BiasByte  = 25'd2;
  localparam logic [LenBits-1:0] BiasShort = 25'd258;
  localparam logic [LenBits-1:0] BiasLong  = 25'd65794;

  localparam logic ReqKey    = 1'b0;
  localparam logic ReqFinish = 1'b1;

  // length class, equal to the number of trailing count bytes
  typedef enum logic [1:0] {
    LC_ONE   = 2'd0,
    LC_BYTE  = 2'd1,
    LC_SHORT = 2'd2,
    LC_LONG  = 2'd3
  } len_class_e;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       symbol_end;
    logic       stream_end;
  } out_rsp_t;

  // one finished run, ready to be serialised
  typedef struct packed {
    logic [KeyBits-1:0] start_key;
    logic [PosBits-1:0] shared;
    len_class_e         cls;
    logic [RemBits-1:0] rem;
    logic               fin;
  } sym_desc_t;

  typedef struct packed {
    logic      push;
    sym_desc_t desc;
  } sym_push_t;

  // byte 0 is the most significant byte of the key
  function automatic logic [7:0] key_byte(input logic [KeyBits-1:0] k,
                                          input logic [PosBits-1:0] b);
    logic [PosBits-1:0] rb;
    rb = ~b;
    return k[{rb, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sorted_key_run_prefix_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key run prefix encoder
// A key that extends the open run is taken with no output. A finished run leaves
// as a symbol of 2 to 36 bytes, one byte per cycle from the serialiser while the
// output is not stalled; its descriptor passes through the queue entry and the
// serialiser's descriptor register before the registered opcode is valid.
// Requests stall only while the descriptor queue is full.
// Reset (async, active low) empties the queue and clears all run state.
// ----------------------------------------------------------------------------
module sorted_key_run_prefix_encoder_unit #(
  parameter int unsigned QueueDepth = skrpe_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire skrpe_pkg::in_req_t in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output skrpe_pkg::out_rsp_t     out_rsp_o
);

  skrpe_pkg::sym_push_t push;
  skrpe_pkg::sym_desc_t q_data;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;

  skrpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  skrpe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  skrpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/skrpe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run encoder front
// Accepts key and finish requests, tracks the open run and hands finished runs
// to the symbol queue as descriptors.
// ----------------------------------------------------------------------------
module skrpe_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire skrpe_pkg::in_req_t in_req_i,
  input  wire logic               q_full_i,
  output skrpe_pkg::sym_push_t    push_o
);

  logic [skrpe_pkg::KeyBits-1:0] next_exp_q, next_exp_d;
  logic [skrpe_pkg::KeyBits-1:0] run_start_q, run_start_d;
  logic [skrpe_pkg::KeyBits-1:0] prior_end_q, prior_end_d;
  logic [skrpe_pkg::LenBits-1:0] run_len_q, run_len_d;
  logic                          run_open_q, run_open_d;

  logic [skrpe_pkg::KeyBits-1:0] key;
  logic [skrpe_pkg::KeyBits-1:0] key_inc;
  logic                          accept;
  logic                          extend;
  logic [skrpe_pkg::PosBits-1:0] shared;
  skrpe_pkg::len_class_e         cls;
  logic [skrpe_pkg::LenBits-1:0] bias;
  logic [skrpe_pkg::LenBits-1:0] rem_full;

  assign key = {in_req_i.key_word0, in_req_i.key_word1,
                in_req_i.key_word2, in_req_i.key_word3};
  assign key_inc = key + {{(skrpe_pkg::KeyBits-1){1'b0}}, 1'b1};

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign extend = run_open_q && (key == next_exp_q) && (run_len_q < skrpe_pkg::RunMax);

  // leading bytes shared with the reference key, capped at the last byte
  always_comb begin
    shared = skrpe_pkg::PosBits'(skrpe_pkg::KeyBytes - 1);
    for (int b = skrpe_pkg::KeyBytes - 2; b >= 0; b--) begin
      if (skrpe_pkg::key_byte(run_start_q, skrpe_pkg::PosBits'(b)) !=
          skrpe_pkg::key_byte(prior_end_q, skrpe_pkg::PosBits'(b))) begin
        shared = skrpe_pkg::PosBits'(b);
      end
    end
  end

  always_comb begin
    if (run_len_q <= skrpe_pkg::LenBits'(1)) begin
      cls  = skrpe_pkg::LC_ONE;
      bias = run_len_q;
    end else if (run_len_q < skrpe_pkg::BiasShort) begin
      cls  = skrpe_pkg::LC_BYTE;
      bias = skrpe_pkg::BiasByte;
    end else if (run_len_q < skrpe_pkg::BiasLong) begin
      cls  = skrpe_pkg::LC_SHORT;
      bias = skrpe_pkg::BiasShort;
    end else begin
      cls  = skrpe_pkg::LC_LONG;
      bias = skrpe_pkg::BiasLong;
    end
  end

  assign rem_full = run_len_q - bias;

  always_comb begin
    next_exp_d  = next_exp_q;
    run_start_d = run_start_q;
    prior_end_d = prior_end_q;
    run_len_d   = run_len_q;
    run_open_d  = run_open_q;

    push_o.push           = 1'b0;
    push_o.desc.start_key = run_start_q;
    push_o.desc.shared    = shared;
    push_o.desc.cls       = cls;
    push_o.desc.rem       = rem_full[skrpe_pkg::RemBits-1:0];
    push_o.desc.fin       = 1'b0;

    if (accept) begin
      if (in_req_i.req_type == skrpe_pkg::ReqFinish) begin
        push_o.push      = run_open_q;
        push_o.desc.fin  = 1'b1;
        next_exp_d  = '0;
        run_start_d = '0;
        prior_end_d = '0;
        run_len_d   = '0;
        run_open_d  = 1'b0;
      end else begin
        next_exp_d = key_inc;
        if (!run_open_q) begin
          run_open_d  = 1'b1;
          run_len_d   = skrpe_pkg::LenBits'(1);
          run_start_d = key;
        end else if (extend) begin
          run_len_d = run_len_q + skrpe_pkg::LenBits'(1);
        end else begin
          push_o.push = 1'b1;
          prior_end_d = next_exp_q;
          run_start_d = key;
          run_len_d   = skrpe_pkg::LenBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_exp_q  <= '0;
      run_start_q <= '0;
      prior_end_q <= '0;
      run_len_q   <= '0;
      run_open_q  <= 1'b0;
    end else begin
      next_exp_q  <= next_exp_d;
      run_start_q <= run_start_d;
      prior_end_q <= prior_end_d;
      run_len_q   <= run_len_d;
      run_open_q  <= run_open_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/skrpe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Symbol descriptor queue
// Small register queue between the run tracker and the byte serialiser.
// ----------------------------------------------------------------------------
module skrpe_queue #(
  parameter int unsigned Depth = skrpe_pkg::QueueDepth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire skrpe_pkg::sym_push_t push_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output skrpe_pkg::sym_desc_t      data_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  skrpe_pkg::sym_desc_t entries_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.desc;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/skrpe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Symbol serialiser
// Takes one descriptor at a time and emits opcode, differing key bytes and
// count bytes through a registered output, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module skrpe_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire skrpe_pkg::sym_desc_t q_data_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output skrpe_pkg::out_rsp_t       out_rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OP   = 4'b0010,
    ST_KEY  = 4'b0100,
    ST_CNT  = 4'b1000
  } ser_state_e;

  ser_state_e                    state_q, state_d;
  skrpe_pkg::sym_desc_t          sym_q, sym_d;
  logic [skrpe_pkg::PosBits-1:0] pos_q, pos_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  skrpe_pkg::out_rsp_t           out_q, out_d;
  logic                          adv;
  logic                          last_key;
  logic [7:0]                    cnt_byte;

  assign adv      = !out_valid_q || !out_stall_i;
  assign last_key = (pos_q == skrpe_pkg::PosBits'(skrpe_pkg::KeyBytes - 1));

  always_comb begin
    case (cnt_q)
      2'd3:    cnt_byte = sym_q.rem[23:16];
      2'd2:    cnt_byte = sym_q.rem[15:8];
      default: cnt_byte = sym_q.rem[7:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          sym_d   = q_data_i;
          state_d = ST_OP;
        end
      end
      ST_OP: begin
        if (adv) begin
          out_valid_d      = 1'b1;
          out_d.out_byte   = {1'b0, sym_q.cls, sym_q.shared};
          out_d.symbol_end = 1'b0;
          out_d.stream_end = 1'b0;
          pos_d            = sym_q.shared;
          state_d          = ST_KEY;
        end
      end
      ST_KEY: begin
        if (adv) begin
          out_valid_d      = 1'b1;
          out_d.out_byte   = skrpe_pkg::key_byte(sym_q.start_key, pos_q);
          out_d.symbol_end = last_key && (sym_q.cls == skrpe_pkg::LC_ONE);
          out_d.stream_end = last_key && (sym_q.cls == skrpe_pkg::LC_ONE) && sym_q.fin;
          if (last_key) begin
            cnt_d   = sym_q.cls;
            state_d = (sym_q.cls == skrpe_pkg::LC_ONE) ? ST_IDLE : ST_CNT;
          end else begin
            pos_d = pos_q + skrpe_pkg::PosBits'(1);
          end
        end
      end
      ST_CNT: begin
        if (adv) begin
          out_valid_d      = 1'b1;
          out_d.out_byte   = cnt_byte;
          out_d.symbol_end = (cnt_q == 2'd1);
          out_d.stream_end = (cnt_q == 2'd1) && sym_q.fin;
          cnt_d            = cnt_q - 2'd1;
          if (cnt_q == 2'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    pos_q <= pos_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// ===== sim/sorted_key_run_prefix_encoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key run prefix encoder testbench
// Streams 256-bit key requests and finish requests into the encoder. A local
// model of the run grouping and symbol layout predicts every output byte, and
// each byte is checked in order. Both handshakes idle at random. A directed
// table covers wrap, the single-key, one-byte and shortest two-byte count
// classes, several shared prefix lengths and empty finishes. A random phase of
// run-shaped key streams with duplicates and noise follows.
// ----------------------------------------------------------------------------
module sorted_key_run_prefix_encoder_unit_tb;

  localparam int IdlePct    = 36;
  localparam int RandItems  = 75;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 80;

  typedef struct packed {
    logic                          fin;
    logic [skrpe_pkg::KeyBits-1:0] key;
    logic [31:0]                   reps;
    logic                          typed;
    logic [7:0]                    n;
    logic [7:0]                    op;
  } plan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  skrpe_pkg::in_req_t  in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  skrpe_pkg::out_rsp_t out_rsp_o;

  // run tracking model
  logic [skrpe_pkg::KeyBits-1:0] run_next_key  = '0;
  logic [skrpe_pkg::KeyBits-1:0] run_first_key = '0;
  logic [skrpe_pkg::KeyBits-1:0] run_ref_key   = '0;
  logic [skrpe_pkg::LenBits-1:0] run_count     = '0;
  logic                          run_active    = 1'b0;

  skrpe_pkg::out_rsp_t sym_bytes_q[$];
  plan_row_t           plan[$];

  int         n_err        = 0;
  int         quiet_cycles = 0;
  logic       calm         = 1'b0;
  logic       row_typed    = 1'b0;
  int         row_n        = 0;
  logic [7:0] row_op       = '0;

  sorted_key_run_prefix_encoder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] byte_of(input logic [skrpe_pkg::KeyBits-1:0] k,
                                         input int b);
    return k[skrpe_pkg::KeyBits-1-8*b -: 8];
  endfunction

  function automatic logic [skrpe_pkg::KeyBits-1:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic skrpe_pkg::in_req_t make_req(input logic fin,
                                                  input logic [skrpe_pkg::KeyBits-1:0] k);
    skrpe_pkg::in_req_t r;
    r.req_type  = fin ? skrpe_pkg::ReqFinish : skrpe_pkg::ReqKey;
    r.key_word0 = k[255:192];
    r.key_word1 = k[191:128];
    r.key_word2 = k[127:64];
    r.key_word3 = k[63:0];
    return r;
  endfunction

  // opcode, differing key bytes, then big-endian count minus bias
  function automatic void serialise_run(input logic fin);
    skrpe_pkg::len_class_e         cls;
    logic [skrpe_pkg::LenBits-1:0] bias;
    logic [skrpe_pkg::LenBits-1:0] rem;
    logic [7:0]                    body[$];
    logic [7:0]                    op_byte;
    int                            j;
    int                            b;
    skrpe_pkg::out_rsp_t           r;
    if (run_count <= 1) begin
      cls = skrpe_pkg::LC_ONE;
      bias = 'd1;
    end else if (run_count < skrpe_pkg::BiasShort) begin
      cls = skrpe_pkg::LC_BYTE;
      bias = skrpe_pkg::BiasByte;
    end else if (run_count < skrpe_pkg::BiasLong) begin
      cls = skrpe_pkg::LC_SHORT;
      bias = skrpe_pkg::BiasShort;
    end else begin
      cls = skrpe_pkg::LC_LONG;
      bias = skrpe_pkg::BiasLong;
    end
    rem = (run_count >= bias) ? run_count - bias : '0;
    j = 0;
    while (j < 31 && byte_of(run_first_key, j) == byte_of(run_ref_key, j)) j++;
    op_byte = {1'b0, cls, 5'(j)};
    body = {body, op_byte};
    for (b = j; b < skrpe_pkg::KeyBytes; b++) body = {body, byte_of(run_first_key, b)};
    for (b = int'(cls) - 1; b >= 0; b--) body = {body, rem[8*b +: 8]};
    for (b = 0; b < body.size(); b++) begin
      r.out_byte   = body[b];
      r.symbol_end = (b == body.size() - 1);
      r.stream_end = fin && (b == body.size() - 1);
      sym_bytes_q = {sym_bytes_q, r};
    end
  endfunction

  function automatic void encode_request(input skrpe_pkg::in_req_t r);
    logic [skrpe_pkg::KeyBits-1:0] k;
    k = {r.key_word0, r.key_word1, r.key_word2, r.key_word3};
    if (r.req_type == skrpe_pkg::ReqFinish) begin
      if (run_active) serialise_run(1'b1);
      run_next_key  = '0;
      run_first_key = '0;
      run_ref_key   = '0;
      run_count     = '0;
      run_active    = 1'b0;
    end else begin
      if (!run_active) begin
        run_active    = 1'b1;
        run_count     = 'd1;
        run_first_key = k;
      end else if (k == run_next_key && run_count < skrpe_pkg::RunMax) begin
        run_count = run_count + 1'b1;
      end else begin
        serialise_run(1'b0);
        run_ref_key   = run_next_key;
        run_first_key = k;
        run_count     = 'd1;
      end
      run_next_key = k + 1'b1;
    end
  endfunction

  // accepted requests feed the model before any byte of this edge is checked
  always @(posedge clk_i) begin : monitor_b
    skrpe_pkg::out_rsp_t want;
    logic                moved;
    int                  n0;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        n0 = sym_bytes_q.size();
        encode_request(in_req_i);
        if (row_typed) begin
          if (sym_bytes_q.size() - n0 != row_n) begin
            $error("byte count: expected %0d, got %0d", row_n, sym_bytes_q.size() - n0);
            n_err++;
          end else if (row_n > 0 && sym_bytes_q[n0].out_byte !== row_op) begin
            $error("opcode: expected %0h, got %0h", row_op, sym_bytes_q[n0].out_byte);
            n_err++;
          end
        end
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (sym_bytes_q.size() == 0) begin
          $error("unexpected output byte %0h", out_rsp_o.out_byte);
          n_err++;
        end else begin
          want = sym_bytes_q.pop_front();
          if (out_rsp_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_rsp_o.out_byte);
            n_err++;
          end
          if (out_rsp_o.symbol_end !== want.symbol_end) begin
            $error("symbol_end: expected %0b, got %0b", want.symbol_end,
                   out_rsp_o.symbol_end);
            n_err++;
          end
          if (out_rsp_o.stream_end !== want.stream_end) begin
            $error("stream_end: expected %0b, got %0b", want.stream_end,
                   out_rsp_o.stream_end);
            n_err++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  task automatic drive_request(input skrpe_pkg::in_req_t r, input logic typed,
                               input int n, input logic [7:0] op);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      in_req_i   <= make_req(1'($urandom_range(0, 1)), rand_key());
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    row_typed  = typed;
    row_n      = n;
    row_op     = op;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic add_row(input logic fin, input logic [skrpe_pkg::KeyBits-1:0] k,
                         input int reps, input int n, input logic [7:0] op);
    plan_row_t row;
    row.fin   = fin;
    row.key   = k;
    row.reps  = reps;
    row.typed = 1'b1;
    row.n     = 8'(n);
    row.op    = op;
    plan = {plan, row};
  endtask

  initial begin : stimulus
    logic [skrpe_pkg::KeyBits-1:0] gen_last;
    logic [skrpe_pkg::KeyBits-1:0] start;
    logic [skrpe_pkg::KeyBits-1:0] step_v;
    int                            sent;
    int                            pick;
    int                            len;
    int                            i;
    int                            r;

    //      fin   key                                           reps   bytes opcode
    add_row(1'b1, '0,                                           1,     0,    8'h00);
    add_row(1'b0, 256'd0,                                       1,     0,    8'h00);
    add_row(1'b0, 256'd5,                                       1,     2,    8'h1F);
    // all ones then zero: the run wraps
    add_row(1'b0, '1,                                           2,     2,    8'h1F);
    add_row(1'b0, 256'd0,                                       1,     34,   8'h20);
    add_row(1'b1, 256'd0,                                       1,     2,    8'h1F);
    add_row(1'b1, 256'd0,                                       1,     0,    8'h00);
    add_row(1'b0, {128'h0, 64'h1234, 64'hFFFF_FFFF_FFFF_FFFF},  258,   0,    8'h00);
    // shortest run of the two-byte count class
    add_row(1'b0, {64'h8000_0000_0000_0000, 192'h0},            1,     13,   8'h56);
    add_row(1'b0, {64'h8000_0000_0000_0000, 128'h0, 64'h1000},  1,     33,   8'h00);
    add_row(1'b0, {64'h8000_0000_0000_0000, 128'h0, 64'h30000}, 1,     3,    8'h1E);
    // key words on a finish are don't-care
    add_row(1'b1, '1,                                           1,     4,    8'h1D);
    add_row(1'b0, 256'd7,                                       1,     0,    8'h00);
    add_row(1'b0, 256'd8,                                       1,     0,    8'h00);
    add_row(1'b0, 256'd3,                                       1,     3,    8'h3F);
    add_row(1'b0, {64'h0, {192{1'b1}}},                         2,     2,    8'h1F);
    add_row(1'b1, 256'd0,                                       1,     26,   8'h28);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < plan.size(); r++) begin
      for (i = 0; i < plan[r].reps; i++) begin
        drive_request(make_req(plan[r].fin, plan[r].key + i), i == 0, plan[r].n,
                      plan[r].op);
      end
    end

    gen_last = {64'h1, 192'h0};
    sent = 0;
    while (sent < RandItems) begin
      calm = (sent >= 15 && sent < 50);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        drive_request(make_req(1'b1, rand_key()), 1'b0, 0, '0);
        sent++;
      end else if (pick < 14) begin
        gen_last = rand_key();
        drive_request(make_req(1'b0, gen_last), 1'b0, 0, '0);
        sent++;
      end else if (pick < 18) begin
        drive_request(make_req(1'b0, gen_last), 1'b0, 0, '0);
        sent++;
      end else begin
        // a run starting near the all-ones key, or past the last key and differing from a random byte on
        if (pick < 21) begin
          start = '1 - $urandom_range(0, 3);
        end else begin
          step_v = $urandom_range(1, 255);
          step_v = step_v << (8 * $urandom_range(0, 31));
          start  = gen_last + 1'b1 + step_v;
        end
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if (len > RandItems - sent) len = RandItems - sent;
        for (i = 0; i < len; i++) begin
          drive_request(make_req(1'b0, start + i), 1'b0, 0, '0);
          sent++;
        end
        gen_last = start + len - 1;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (sym_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
